// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Request and result types, operation codes and status codes of the
// double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // Operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] value_in;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic [1:0]               status;
    logic                     last;
  } deq_out_t;

endpackage

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Push results (ok or full) and error results sit in the output register from the
// cycle after the request is taken; pushes are taken back to back, one a cycle,
// while the output is not stalled. A successful pop does one RAM read and then
// registers the value; a dump reads each value, then waits for a free output.
// Reset clears the front pointer, the entry count and the control state; the
// entry store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a ring held in a
// synchronous RAM. Supports push/pop at either end and an ordered dump.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire deq_pkg::deq_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output deq_pkg::deq_out_t     out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Control states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_POP     = 2'd1;
  localparam logic [1:0] S_DUMP_RD = 2'd2;
  localparam logic [1:0] S_DUMP_WT = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] dump_idx_q, dump_idx_d;

  logic              out_valid_q, out_valid_d;
  deq_pkg::deq_out_t out_data_q, out_data_d;

  logic                      ram_wr_en;
  logic [AW-1:0]             ram_wr_addr;
  logic                      ram_rd_en;
  logic [AW-1:0]             ram_rd_addr;
  logic [deq_pkg::DATA_W-1:0] ram_rd_data;

  logic out_free;
  logic accept;
  logic is_full;
  logic is_empty;
  logic dump_last;

  // Ring position front + off, wrapped into 0..DEPTH-1
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] front,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, front} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  // Output register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q == DEPTH_C);
  assign is_empty   = (count_q == '0);
  assign dump_last  = ((CW'(dump_idx_q) + CW'(1)) == count_q);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    dump_idx_d  = dump_idx_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ring_pos(front_q, count_q[AW-1:0]);
    ram_rd_en   = 1'b0;
    ram_rd_addr = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.operation) inside
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              out_valid_d          = 1'b1;
              out_data_d.value_out = '0;
              out_data_d.last      = 1'b1;
              if (is_full) begin
                out_data_d.status = deq_pkg::ST_FULL;
              end else begin
                out_data_d.status = deq_pkg::ST_OK;
                ram_wr_en         = 1'b1;
                count_d           = count_q + CW'(1);
                if (in_data_i.operation == deq_pkg::OP_PUSH_FRONT) begin
                  front_d     = ring_pos(front_q, LAST_A);
                  ram_wr_addr = ring_pos(front_q, LAST_A);
                end
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                out_valid_d          = 1'b1;
                out_data_d.value_out = '0;
                out_data_d.status    = deq_pkg::ST_EMPTY;
                out_data_d.last      = 1'b1;
              end else begin
                ram_rd_en = 1'b1;
                count_d   = count_q - CW'(1);
                state_d   = S_POP;
                if (in_data_i.operation == deq_pkg::OP_POP_FRONT) begin
                  front_d = ring_pos(front_q, AW'(1));
                end else begin
                  ram_rd_addr = ring_pos(front_q, count_q[AW-1:0] - AW'(1));
                end
              end
            end
            deq_pkg::OP_DUMP: begin
              if (is_empty) begin
                out_valid_d          = 1'b1;
                out_data_d.value_out = '0;
                out_data_d.status    = deq_pkg::ST_EMPTY;
                out_data_d.last      = 1'b1;
              end else begin
                dump_idx_d = '0;
                state_d    = S_DUMP_RD;
              end
            end
            default: begin
              // unused codes: no result, no change
            end
          endcase
        end
      end

      // Popped value arrives; output register is known to be free
      S_POP: begin
        out_valid_d          = 1'b1;
        out_data_d.value_out = ram_rd_data;
        out_data_d.status    = deq_pkg::ST_OK;
        out_data_d.last      = 1'b1;
        state_d              = S_IDLE;
      end

      // Walk the ring from front to back
      S_DUMP_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = ring_pos(front_q, dump_idx_q);
        state_d     = S_DUMP_WT;
      end

      S_DUMP_WT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_data_d.value_out = ram_rd_data;
          out_data_d.status    = deq_pkg::ST_OK;
          out_data_d.last      = dump_last;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            dump_idx_d = dump_idx_q + AW'(1);
            state_d    = S_DUMP_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dump_idx_q <= dump_idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Entry store
  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (in_data_i.value_in),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

endmodule

`default_nettype wire

// ===== design/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port RAM: one write port, one read port with registered
// read data. Read data holds while rd_en_i is low.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  wire logic [WIDTH-1:0]                 wr_data_i,
  input  wire logic                             rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic      [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the double-ended queue. A queue of pending requests
// feeds a clocked driver. Every accepted request is run through a local model
// of the ring store, and the model queues the results it expects. A clocked
// monitor checks each result field by field, in order. Phases vary the idle
// rate on the request side and the stall rate on the result side. One phase
// holds off the result side long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int          HOLD_LEN   = 100;
  localparam int          TAIL_WAIT  = 3 * DEPTH + 10;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          PRINT_CAP  = 50;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  deq_pkg::deq_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  deq_pkg::deq_out_t out_data_o;

  double_ended_queue #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Requests waiting to be driven and results the queue model predicts
  deq_pkg::deq_in_t  pending_requests[$];
  deq_pkg::deq_out_t expected_results[$];

  // Queue model state
  logic signed [deq_pkg::DATA_W-1:0] ring_model[DEPTH];
  logic [IDX_W-1:0]                  head_model = '0;
  logic [IDX_W:0]                    fill_model = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP)
      $display("%0t MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Append to the request queue and to the expected-result queue
  function automatic void queue_request(input deq_pkg::deq_in_t req);
    pending_requests = {pending_requests, req};
  endfunction

  function automatic void expect_result(input deq_pkg::deq_out_t res);
    expected_results = {expected_results, res};
  endfunction

  // Apply one request to the model ring and queue the results it causes
  task automatic deq_model_apply(input deq_pkg::deq_in_t req);
    logic [IDX_W-1:0]  pos;
    deq_pkg::deq_out_t res;
    int                i;
    res        = '0;
    res.last   = 1'b1;
    res.status = deq_pkg::ST_OK;
    case (req.operation) inside
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (fill_model == DEPTH) begin
          res.status = deq_pkg::ST_FULL;
        end else begin
          if (req.operation == deq_pkg::OP_PUSH_FRONT) begin
            head_model = head_model - 1'b1;
            pos        = head_model;
          end else begin
            pos = IDX_W'(head_model + fill_model);
          end
          ring_model[pos] = req.value_in;
          fill_model++;
        end
        expect_result(res);
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (fill_model == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else begin
          if (req.operation == deq_pkg::OP_POP_FRONT) begin
            pos        = head_model;
            head_model = head_model + 1'b1;
          end else begin
            pos = IDX_W'(head_model + fill_model - 1'b1);
          end
          fill_model--;
          res.value_out = ring_model[pos];
        end
        expect_result(res);
      end
      deq_pkg::OP_DUMP: begin
        if (fill_model == 0) begin
          res.status = deq_pkg::ST_EMPTY;
          expect_result(res);
        end else begin
          for (i = 0; i < fill_model; i++) begin
            pos           = head_model + i[IDX_W-1:0];
            res.value_out = ring_model[pos];
            res.last      = (i == fill_model - 1);
            expect_result(res);
          end
        end
      end
      default: ; // unused codes are ignored by the block
    endcase
  endtask

  // Driver: model each accepted request; take the next once the last is gone
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        deq_model_apply(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_requests[0];
          pending_requests.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result-side stall: random, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : result_monitor
    deq_pkg::deq_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d last %0b",
                                  out_data_o.value_out, out_data_o.status,
                                  out_data_o.last));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_data_o.value_out !== want.value_out)
          report_mismatch($sformatf("value_out got %0d want %0d",
                                    out_data_o.value_out, want.value_out));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data_o.status, want.status));
        if (out_data_o.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b",
                                    out_data_o.last, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic deq_pkg::deq_in_t make_request(
      input logic [2:0]                  op,
      input logic signed [deq_pkg::DATA_W-1:0] val);
    deq_pkg::deq_in_t req;
    req.operation = op;
    req.value_in  = val;
    return req;
  endfunction

  // Random value with a bias towards the extremes
  function automatic logic signed [deq_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random request; fill_bias is the share of pushes among pushes and pops
  function automatic deq_pkg::deq_in_t rand_request(input int fill_bias);
    int          roll;
    logic [2:0]  op;
    roll = $urandom_range(99);
    if (roll < 3)
      op = 3'($urandom_range(7, 5));
    else if (roll < 11)
      op = deq_pkg::OP_DUMP;
    else if ($urandom_range(99) < fill_bias)
      op = $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
    else
      op = $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
    return make_request(op, rand_value());
  endfunction

  task automatic wait_quiet();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Random phase: the push bias swings between filling and draining
  task automatic run_phase(input int n_items, input int idle_pct, input int stall);
    int k;
    @(negedge clk_i);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (k = 0; k < n_items; k++)
      queue_request(rand_request(((k / 20) % 2 == 0) ? 75 : 25));
    wait_quiet();
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int k;

    // Empty-queue cases, unused code, push extremes and pops of them
    queue_request(make_request(deq_pkg::OP_POP_FRONT, rand_value()));
    queue_request(make_request(deq_pkg::OP_POP_BACK, rand_value()));
    queue_request(make_request(deq_pkg::OP_DUMP, rand_value()));
    queue_request(make_request(3'd7, rand_value()));
    queue_request(make_request(deq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff));
    queue_request(make_request(deq_pkg::OP_PUSH_BACK, 32'sh8000_0000));
    queue_request(make_request(deq_pkg::OP_POP_BACK, '0));
    queue_request(make_request(deq_pkg::OP_POP_FRONT, -32'sd1));
    // Fill to the brim from both ends, overflow at both ends, dump it all
    for (k = 0; k < DEPTH; k++)
      queue_request(make_request(k[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                                 rand_value()));
    queue_request(make_request(deq_pkg::OP_PUSH_BACK, rand_value()));
    queue_request(make_request(deq_pkg::OP_PUSH_FRONT, rand_value()));
    queue_request(make_request(deq_pkg::OP_DUMP, '0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_quiet();

    run_phase(70, 0, 0);
    run_phase(70, 72, 0);
    run_phase(70, 0, 72);
    run_phase(70, 33, 33);

    // Back-pressure: result side held off while requests keep coming
    @(negedge clk_i);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = hold_req + 1;
    for (k = 0; k < 24; k++)
      queue_request(rand_request(80));
    wait_quiet();

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
